/* rtl/core/mrwr_pkg.sv */
// shared constants for the miller-rabin witness round block
// no dependencies
package mrwr_pkg;
  localparam int FIELD_W     = 32;
  localparam int WIDTH_DEF   = 32;

  // control states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CHECK  = 4'd1;
  localparam logic [3:0] ST_DECOMP = 4'd2;
  localparam logic [3:0] ST_RED    = 4'd3;
  localparam logic [3:0] ST_POW    = 4'd4;
  localparam logic [3:0] ST_MR     = 4'd5;
  localparam logic [3:0] ST_MS     = 4'd6;
  localparam logic [3:0] ST_SQ     = 4'd7;
  localparam logic [3:0] ST_FIN    = 4'd8;
endpackage

/* rtl/core/mrwr_mulmod.sv */
// bit-serial modular multiplier: p * q mod m, one bit of q per cycle
// uses mrwr_pkg for the default width
module mrwr_mulmod #(
  parameter int W = mrwr_pkg::WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] p,
  input  logic [W-1:0] q,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] result
);
  import mrwr_pkg::*;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  q_r, p_r, m_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [W:0]    dbl, dbl_red, sum;

  always_comb begin
    // acc = 2*acc mod m, then add p mod m when the bit is set
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    sum     = dbl_red + {1'b0, p_r};
    if (q_r[W-1]) begin
      if (sum >= {1'b0, m_r}) sum = sum - {1'b0, m_r};
      acc_nxt = sum[W-1:0];
    end else begin
      acc_nxt = dbl_red[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      q_r   <= q;
      p_r   <= p;
      m_r   <= m;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      q_r   <= {q_r[W-2:0], 1'b0};
    end
  end

  assign done   = done_r;
  assign result = acc_r;
endmodule

/* rtl/core/miller_rabin_witness_round_top.sv */
// miller-rabin witness round: control sequencer and datapath registers
// uses mrwr_pkg and mrwr_mulmod
//
// channel | ports                                   | dir
// in      | in_valid in_ready in_candidate in_witness | in
// out     | out_valid out_ready out_probably_prime    | out
//
// one item at a time; n - 1 = d * 2^s, L is the bit length of d, and a round
// uses up to M = L + popcount(d) + s modular products of K = min(WIDTH, 32) bits
// on the bit-serial multiplier.
// synchronous active-low reset returns to idle with no result pending.
// a finished result sits in the output register; the next item is taken
// while it waits, and a second result holds until the first transfer.
module miller_rabin_witness_round_top #(
  parameter int WIDTH = mrwr_pkg::WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mrwr_pkg::FIELD_W-1:0] in_candidate,
  input  logic [mrwr_pkg::FIELD_W-1:0] in_witness,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_probably_prime
);
  import mrwr_pkg::*;
  localparam int DW = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;
  localparam int SW = $clog2(DW + 1);

  logic [3:0]    state_r, state_nxt;
  logic [DW-1:0] n_r, n_nxt, a_r, a_nxt, d_r, d_nxt, x_r, x_nxt;
  logic [SW-1:0] s_r, s_nxt, rc_r, rc_nxt;
  logic          pass_r, pass_nxt;
  logic          out_valid_r, out_valid_nxt, out_pp_r, out_pp_nxt;
  logic          mm_start, mm_done;
  logic [DW-1:0] mm_p, mm_q, mm_res, nm1;

  mrwr_mulmod #(.W(DW)) u_mulmod (
    .clk(clk), .rst_n(rst_n), .start(mm_start),
    .p(mm_p), .q(mm_q), .m(n_r), .done(mm_done), .result(mm_res)
  );

  assign nm1      = n_r - 1'b1;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    a_nxt         = a_r;
    d_nxt         = d_r;
    x_nxt         = x_r;
    s_nxt         = s_r;
    rc_nxt        = rc_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r;
    out_pp_nxt    = out_pp_r;
    mm_start      = 1'b0;
    mm_p          = x_r;
    mm_q          = x_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          n_nxt     = in_candidate[DW-1:0];
          a_nxt     = in_witness[DW-1:0];
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (n_r < DW'(2) || (n_r != DW'(2) && !n_r[0])) begin
          pass_nxt  = 1'b0;
          state_nxt = ST_FIN;
        end else if (n_r == DW'(2)) begin
          pass_nxt  = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          d_nxt     = nm1;
          s_nxt     = '0;
          state_nxt = ST_DECOMP;
        end
      end
      ST_DECOMP: begin
        if (!d_r[0]) begin
          d_nxt = d_r >> 1;
          s_nxt = s_r + 1'b1;
        end else begin
          // reduce the clamped base: 1 * a mod n
          mm_start  = 1'b1;
          mm_p      = DW'(1);
          mm_q      = (a_r < DW'(2)) ? DW'(2) : a_r;
          state_nxt = ST_RED;
        end
      end
      ST_RED: begin
        if (mm_done) begin
          a_nxt     = mm_res;
          x_nxt     = DW'(1);
          state_nxt = ST_POW;
        end
      end
      ST_POW: begin
        if (d_r == '0) begin
          if (x_r == DW'(1) || x_r == nm1) begin
            pass_nxt  = 1'b1;
            state_nxt = ST_FIN;
          end else if (s_r <= SW'(1)) begin
            pass_nxt  = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            rc_nxt    = SW'(1);
            mm_start  = 1'b1;
            state_nxt = ST_SQ;
          end
        end else if (d_r[0]) begin
          mm_start  = 1'b1;
          mm_p      = x_r;
          mm_q      = a_r;
          state_nxt = ST_MR;
        end else begin
          mm_start  = 1'b1;
          mm_p      = a_r;
          mm_q      = a_r;
          state_nxt = ST_MS;
        end
      end
      ST_MR: begin
        mm_p = a_r;
        mm_q = a_r;
        if (mm_done) begin
          x_nxt     = mm_res;
          mm_start  = 1'b1;
          state_nxt = ST_MS;
        end
      end
      ST_MS: begin
        if (mm_done) begin
          a_nxt     = mm_res;
          d_nxt     = d_r >> 1;
          state_nxt = ST_POW;
        end
      end
      ST_SQ: begin
        if (mm_done) begin
          x_nxt = mm_res;
          if (mm_res == nm1) begin
            pass_nxt  = 1'b1;
            state_nxt = ST_FIN;
          end else if (rc_r + 1'b1 >= s_r) begin
            pass_nxt  = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            rc_nxt   = rc_r + 1'b1;
            mm_p     = mm_res;
            mm_q     = mm_res;
            mm_start = 1'b1;
          end
        end
      end
      ST_FIN: begin
        // wait until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_pp_nxt    = pass_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    a_r      <= a_nxt;
    d_r      <= d_nxt;
    x_r      <= x_nxt;
    s_r      <= s_nxt;
    rc_r     <= rc_nxt;
    pass_r   <= pass_nxt;
    out_pp_r <= out_pp_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_probably_prime = out_pp_r;
endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// testbench for miller_rabin_witness_round_top: one witness round per transfer
// depends on mrwr_pkg and the rtl; self-checking against a behavioral witness-round model
module tb_top;
  import mrwr_pkg::*;

  localparam int W = WIDTH_DEF;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [FIELD_W-1:0] in_candidate;
  logic [FIELD_W-1:0] in_witness;
  logic out_valid;
  logic out_ready;
  logic out_probably_prime;

  bit verdicts_q[$];
  int errors;
  bit quiet_mode;

  miller_rabin_witness_round_top #(.WIDTH(W)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_candidate(in_candidate), .in_witness(in_witness),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_probably_prime(out_probably_prime)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // exact modular product, 64-bit operands held in 128-bit intermediate
  function automatic logic [63:0] mod_mul(logic [63:0] p, logic [63:0] q, logic [63:0] m);
    logic [127:0] prod;
    prod = {64'd0, p} * {64'd0, q};
    return 64'(prod % {64'd0, m});
  endfunction

  function automatic logic [63:0] mod_pow(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1 % m;
    sq = b % m;
    while (e != 0) begin
      if (e[0]) acc = mod_mul(acc, sq, m);
      sq = mod_mul(sq, sq, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic bit round_verdict(logic [FIELD_W-1:0] cand, logic [FIELD_W-1:0] wit);
    logic [63:0] n;
    logic [63:0] a;
    logic [63:0] d;
    logic [63:0] x;
    int s;
    n = 64'(cand);
    a = 64'(wit);
    if (W < 64) begin
      n = n & ((64'd1 << W) - 1);
      a = a & ((64'd1 << W) - 1);
    end
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (!n[0]) return 1'b0;
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    if (a < 2) a = 2;
    x = mod_pow(a, d, n);
    if (x == 1 || x == n - 1) return 1'b1;
    for (int r = 1; r < s; r++) begin
      x = mod_mul(x, x, n);
      if (x == n - 1) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit idle_now();
    return !quiet_mode && ($urandom_range(99) < 16);
  endfunction

  task automatic send_round(logic [FIELD_W-1:0] cand, logic [FIELD_W-1:0] wit);
    while (idle_now()) @(posedge clk);
    in_valid <= 1'b1;
    in_candidate <= cand;
    in_witness <= wit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    verdicts_q.push_back(round_verdict(cand, wit));
    in_valid <= 1'b0;
    // in_ready drops after a transfer while the block works on the item
    @(posedge clk);
  endtask

  // result side: random back-pressure and in-order compare
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdicts_q.size() == 0) begin
        $display("%0t: result transfer with none expected, actual %0b", $time,
                 out_probably_prime);
        errors++;
      end else begin
        bit want;
        want = verdicts_q.pop_front();
        if (out_probably_prime !== want) begin
          $display("%0t: probably_prime expected %0b actual %0b", $time, want,
                   out_probably_prime);
          errors++;
        end
      end
    end
    out_ready <= !idle_now();
  end

  task automatic wait_drained();
    while (verdicts_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_round(32'd0, 32'd5);
    send_round(32'd1, 32'd0);
    send_round(32'd2, 32'hFFFFFFFF);
    send_round(32'd2, 32'd0);
    send_round(32'd4, 32'd3);
    send_round(32'hFFFFFFFE, 32'd7);
    send_round(32'd3, 32'd0);
    send_round(32'd3, 32'd1);
    send_round(32'd7, 32'd14);
    send_round(32'd7, 32'd9);
    send_round(32'd561, 32'd2);
    send_round(32'd2047, 32'd2);
    send_round(32'd3215031751, 32'd2);
    send_round(32'hFFFFFFFB, 32'hFFFFFFFF);
    send_round(32'hFFFFFFFF, 32'hFFFFFFFE);
    send_round(32'hFFFFFFFB, 32'h12345678);
    send_round(32'h7FFFFFFF, 32'd3);
    send_round(32'h80000001, 32'hAAAAAAAA);
    send_round(32'd65537, 32'h55555555);
    send_round(32'd9, 32'd8);
  endtask

  task automatic test_pause_until_drained();
    send_round(32'd97, 32'd5);
    send_round(32'd91, 32'd10);
    wait_drained();
    send_round(32'd4294967291, 32'd2);
  endtask

  task automatic test_random(int count);
    logic [FIELD_W-1:0] cand;
    logic [FIELD_W-1:0] wit;
    for (int i = 0; i < count; i++) begin
      quiet_mode = (i >= 40 && i < 70);
      case ($urandom_range(5))
        0: cand = $urandom_range(20);
        1: cand = $urandom;
        2: cand = 32'hFFFF0000 | $urandom_range(16'hFFFF);
        default: cand = $urandom | 32'd1;
      endcase
      case ($urandom_range(3))
        0: wit = $urandom_range(3);
        1: wit = cand - $urandom_range(1);
        default: wit = $urandom;
      endcase
      send_round(cand, wit);
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_candidate = '0;
    in_witness = '0;
    out_ready = 1'b0;
    errors = 0;
    quiet_mode = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pause_until_drained();
    test_random(120);
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
